/* rtl/core/hiert_pkg.sv */
package hiert_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int NITER = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int CORDIC_X0    = 652032874;

    // angle mod 46080 = ((a >> 10) mod 45) * 1024 + a[9:0]
    localparam int WRAP_MOD   = 45;
    localparam int WRAP_OFS   = 16425;   // 365 * 45, lifts a >> 10 above zero
    localparam int WRAP_RECIP = 46604;   // ceil(2^21 / 45)
    localparam int WRAP_SHIFT = 21;

    localparam int LATENCY = 8 + NITER;

    typedef struct packed {
        logic               hp;
        logic signed [31:0] ppx;
        logic signed [31:0] ppy;
        logic signed [15:0] psx;
        logic signed [15:0] psy;
        logic signed [31:0] lpx;
        logic signed [31:0] lpy;
        logic signed [15:0] lsx;
        logic signed [15:0] lsy;
        logic        [15:0] wa;
        logic        [15:0] wla;
    } t_item;

    // atan(2^-i) in units of 2^-23 degree
    function automatic logic signed [31:0] atan_val(input int i);
        logic signed [31:0] v;
        begin
            case (i)
                0:  v = 32'sd377487360;
                1:  v = 32'sd222843801;
                2:  v = 32'sd117744544;
                3:  v = 32'sd59768969;
                4:  v = 32'sd30000467;
                5:  v = 32'sd15014858;
                6:  v = 32'sd7509261;
                7:  v = 32'sd3754860;
                8:  v = 32'sd1877459;
                9:  v = 32'sd938733;
                10: v = 32'sd469367;
                11: v = 32'sd234683;
                12: v = 32'sd117342;
                13: v = 32'sd58671;
                14: v = 32'sd29335;
                15: v = 32'sd14668;
                16: v = 32'sd7334;
                17: v = 32'sd3667;
                18: v = 32'sd1833;
                19: v = 32'sd917;
                20: v = 32'sd458;
                21: v = 32'sd229;
                22: v = 32'sd115;
                default: v = 32'sd57;
            endcase
            return v;
        end
    endfunction

endpackage

/* rtl/core/hierarchical_transform_2d.sv */
// 2d scene-graph transform composition, fully pipelined. one item is accepted
// on every clock where start is high (busy is always low) and its result comes
// out on o_strobe, one result per item, in order. the depth is set by the
// angle wrap (3 stages), one cordic stage per iteration, the quadrant fold
// and four multiply / round / saturate stages. the receiver cannot stall
// the block, so every result must be taken in its strobe cycle. results for
// root items pass the local values through with only the angle wrapped
module hierarchical_transform_2d import hiert_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_has_parent,
    input  logic signed [31:0] i_parent_pos_x,
    input  logic signed [31:0] i_parent_pos_y,
    input  logic signed [15:0] i_parent_scale_x,
    input  logic signed [15:0] i_parent_scale_y,
    input  logic signed [23:0] i_parent_angle,
    input  logic signed [31:0] i_local_pos_x,
    input  logic signed [31:0] i_local_pos_y,
    input  logic signed [15:0] i_local_scale_x,
    input  logic signed [15:0] i_local_scale_y,
    input  logic signed [23:0] i_local_angle,
    output logic               o_strobe,
    output logic signed [31:0] o_world_pos_x,
    output logic signed [31:0] o_world_pos_y,
    output logic signed [15:0] o_world_scale_x,
    output logic signed [15:0] o_world_scale_y,
    output logic        [15:0] o_world_angle,
    output logic        [15:0] o_wrapped_local_angle
);

    // no backpressure anywhere
    assign busy = 1'b0;

    // ---------------- stage 0: angle pre-wrap -----------------
    // three angles: parent (for cordic), world, local
    logic signed [24:0] w_a [3];
    logic signed [16:0] w_u [3];
    logic        [15:0] r0_u [3];
    logic        [9:0]  r0_l [3];
    t_item              r0_it;
    logic               r0_v;

    always_comb begin
        w_a[0] = {i_parent_angle[23], i_parent_angle};
        w_a[2] = {i_local_angle[23], i_local_angle};
        w_a[1] = i_has_parent ? (w_a[0] + w_a[2]) : w_a[2];
        for (int k = 0; k < 3; k++) begin
            w_u[k] = 17'(w_a[k] >>> 10) + 17'(WRAP_OFS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= start;
        end
        for (int k = 0; k < 3; k++) begin
            r0_u[k] <= w_u[k][15:0];
            r0_l[k] <= w_a[k][9:0];
        end
        r0_it.hp  <= i_has_parent;
        r0_it.ppx <= i_parent_pos_x;
        r0_it.ppy <= i_parent_pos_y;
        r0_it.psx <= i_parent_scale_x;
        r0_it.psy <= i_parent_scale_y;
        r0_it.lpx <= i_local_pos_x;
        r0_it.lpy <= i_local_pos_y;
        r0_it.lsx <= i_local_scale_x;
        r0_it.lsy <= i_local_scale_y;
        r0_it.wa  <= '0;
        r0_it.wla <= '0;
    end

    // ---------------- stage 1: quotient by 45 via reciprocal --
    logic [31:0] w_prod [3];
    logic [15:0] r1_u [3];
    logic [9:0]  r1_q [3];
    logic [9:0]  r1_l [3];
    t_item       r1_it;
    logic        r1_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_prod[k] = 32'(r0_u[k]) * 32'(WRAP_RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
        for (int k = 0; k < 3; k++) begin
            r1_u[k] <= r0_u[k];
            r1_q[k] <= w_prod[k][WRAP_SHIFT +: 10];
            r1_l[k] <= r0_l[k];
        end
        r1_it <= r0_it;
    end

    // ---------------- stage 2: remainder, quadrant split ------
    logic [15:0] w_rem [3];
    logic [15:0] w_ang [3];
    logic [1:0]  w_quad;
    logic [15:0] w_res;
    t_item       w_it2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rem[k] = r1_u[k] - 16'(r1_q[k]) * 16'(WRAP_MOD);
            w_ang[k] = {w_rem[k][5:0], r1_l[k]};
        end
        if (w_ang[0] >= 16'(3 * QUARTER_TURN)) begin
            w_quad = 2'd3;
        end else if (w_ang[0] >= 16'(2 * QUARTER_TURN)) begin
            w_quad = 2'd2;
        end else if (w_ang[0] >= 16'(QUARTER_TURN)) begin
            w_quad = 2'd1;
        end else begin
            w_quad = 2'd0;
        end
        w_res = w_ang[0] - 16'(QUARTER_TURN) * 16'(w_quad);
        // wrapped world and local angles ride along with the item
        w_it2     = r1_it;
        w_it2.wa  = w_ang[1];
        w_it2.wla = w_ang[2];
    end

    // ---------------- cordic stages ---------------------------
    logic signed [32:0] r_cx [NITER+1];
    logic signed [32:0] r_cy [NITER+1];
    logic signed [31:0] r_cz [NITER+1];
    logic        [1:0]  r_cq [NITER+1];
    t_item              r_ci [NITER+1];
    logic               r_cv [NITER+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else begin
            r_cv[0] <= r1_v;
        end
        r_cx[0]     <= 33'(CORDIC_X0);
        r_cy[0]     <= '0;
        r_cz[0]     <= {w_res[14:0], 16'd0} ;
        r_cq[0]     <= w_quad;
        r_ci[0]     <= w_it2;
    end

    for (genvar i = 0; i < NITER; i++) begin : g_cordic
        logic signed [32:0] w_dx;
        logic signed [32:0] w_dy;
        assign w_dx = r_cy[i] >>> i;
        assign w_dy = r_cx[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else begin
                r_cv[i+1] <= r_cv[i];
            end
            if (!r_cz[i][31]) begin
                r_cx[i+1] <= r_cx[i] - w_dx;
                r_cy[i+1] <= r_cy[i] + w_dy;
                r_cz[i+1] <= r_cz[i] - atan_val(i);
            end else begin
                r_cx[i+1] <= r_cx[i] + w_dx;
                r_cy[i+1] <= r_cy[i] - w_dy;
                r_cz[i+1] <= r_cz[i] + atan_val(i);
            end
            r_cq[i+1] <= r_cq[i];
            r_ci[i+1] <= r_ci[i];
        end
    end

    // ---------------- quadrant fold ---------------------------
    logic signed [32:0] r4_c;
    logic signed [32:0] r4_s;
    t_item              r4_it;
    logic               r4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r_cv[NITER];
        end
        case (r_cq[NITER])
            2'd0: begin
                r4_c <= r_cx[NITER];
                r4_s <= r_cy[NITER];
            end
            2'd1: begin
                r4_c <= -r_cy[NITER];
                r4_s <= r_cx[NITER];
            end
            2'd2: begin
                r4_c <= -r_cx[NITER];
                r4_s <= -r_cy[NITER];
            end
            default: begin
                r4_c <= r_cy[NITER];
                r4_s <= -r_cx[NITER];
            end
        endcase
        r4_it <= r_ci[NITER];
    end

    // ---------------- rotation products -----------------------
    logic signed [64:0] r5_xc, r5_ys, r5_xs, r5_yc;
    t_item              r5_it;
    logic               r5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_xc <= 65'(r4_it.lpx) * 65'(r4_c);
        r5_ys <= 65'(r4_it.lpy) * 65'(r4_s);
        r5_xs <= 65'(r4_it.lpx) * 65'(r4_s);
        r5_yc <= 65'(r4_it.lpy) * 65'(r4_c);
        r5_it <= r4_it;
    end

    // ---------------- rotate sum and round to q16.16 ----------
    logic signed [65:0] w_sx, w_sy;
    logic signed [35:0] r6_rx, r6_ry;
    t_item              r6_it;
    logic               r6_v;

    always_comb begin
        w_sx = 66'(r5_xc) - 66'(r5_ys) + 66'sd536870912;
        w_sy = 66'(r5_xs) + 66'(r5_yc) + 66'sd536870912;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_rx <= 36'(w_sx >>> 30);
        r6_ry <= 36'(w_sy >>> 30);
        r6_it <= r5_it;
    end

    // ---------------- scale products --------------------------
    logic signed [51:0] r7_mx, r7_my;
    logic signed [31:0] r7_sx, r7_sy;
    t_item              r7_it;
    logic               r7_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        r7_mx <= 52'(r6_rx) * 52'(r6_it.psx);
        r7_my <= 52'(r6_ry) * 52'(r6_it.psy);
        r7_sx <= 32'(r6_it.psx) * 32'(r6_it.lsx);
        r7_sy <= 32'(r6_it.psy) * 32'(r6_it.lsy);
        r7_it <= r6_it;
    end

    // ---------------- round, offset, saturate -----------------
    logic signed [52:0] w_px, w_py;
    logic signed [31:0] w_qx, w_qy;
    logic signed [31:0] w_fx, w_fy;
    logic signed [15:0] w_gx, w_gy;

    always_comb begin
        w_px = 53'(r7_it.ppx) + ((53'(r7_mx) + 53'sd128) >>> 8);
        w_py = 53'(r7_it.ppy) + ((53'(r7_my) + 53'sd128) >>> 8);
        w_qx = (r7_sx + 32'sd128) >>> 8;
        w_qy = (r7_sy + 32'sd128) >>> 8;

        if (w_px > 53'sd2147483647) begin
            w_fx = 32'sh7fffffff;
        end else if (w_px < -53'sd2147483648) begin
            w_fx = 32'sh80000000;
        end else begin
            w_fx = w_px[31:0];
        end
        if (w_py > 53'sd2147483647) begin
            w_fy = 32'sh7fffffff;
        end else if (w_py < -53'sd2147483648) begin
            w_fy = 32'sh80000000;
        end else begin
            w_fy = w_py[31:0];
        end
        if (w_qx > 32'sd32767) begin
            w_gx = 16'sh7fff;
        end else if (w_qx < -32'sd32768) begin
            w_gx = 16'sh8000;
        end else begin
            w_gx = w_qx[15:0];
        end
        if (w_qy > 32'sd32767) begin
            w_gy = 16'sh7fff;
        end else if (w_qy < -32'sd32768) begin
            w_gy = 16'sh8000;
        end else begin
            w_gy = w_qy[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r7_v;
        end
        // root items pass their local values through
        o_world_pos_x         <= r7_it.hp ? w_fx : r7_it.lpx;
        o_world_pos_y         <= r7_it.hp ? w_fy : r7_it.lpy;
        o_world_scale_x       <= r7_it.hp ? w_gx : r7_it.lsx;
        o_world_scale_y       <= r7_it.hp ? w_gy : r7_it.lsy;
        o_world_angle         <= r7_it.wa;
        o_wrapped_local_angle <= r7_it.wla;
    end

    // ---------------- assertions ------------------------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LATENCY))
        else $error("result without an item accepted LATENCY clocks before");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_world_angle < 16'(FULL_TURN)) &&
                     (o_wrapped_local_angle < 16'(FULL_TURN)))
        else $error("wrapped angle out of range");

    a_cordic_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv[0] |-> (r_cz[0] >= 0) && (r_cz[0] < 32'(QUARTER_TURN) * 32'sd65536))
        else $error("cordic residual angle out of quadrant");

endmodule
